// ----- sv/prgbblur_pkg.sv -----
// Package: constants, register map and arithmetic helpers for the packed RGB 3x3 blur.
`timescale 1ns / 1ps

package prgbblur_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int WIDTH_W   = 11;
	localparam int HEIGHT_W  = 12;
	localparam int ROW_W     = HEIGHT_W + 1;
	localparam int PIX_W     = 32;
	localparam int CLR_W     = COL_W + 1;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(640);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(480);
	localparam logic [PIX_W-1:0]    RB_MASK_RST = 32'h00FF_00FF;
	localparam logic [PIX_W-1:0]    G_MASK_RST  = 32'h0000_FF00;
	localparam logic [WIDTH_W-1:0]  WIDTH_MAX  = WIDTH_W'(MAX_WIDTH);

	typedef enum logic [2:0] {
		REG_BLUR_ENABLE   = 3'd0,
		REG_FRAME_WIDTH   = 3'd1,
		REG_FRAME_HEIGHT  = 3'd2,
		REG_RED_BLUE_MASK = 3'd3,
		REG_GREEN_MASK    = 3'd4
	} reg_idx_t;

	typedef logic [PIX_W-1:0] pix_t;

	// Border replication selects for one output position.
	typedef struct packed {
		logic top;
		logic bottom;
		logic left;
		logic right;
	} edge_sel_t;

	// 1 2 1 weighted sum of three masked cells, wrapping at 32 bits.
	function automatic pix_t row_sum(input pix_t a, input pix_t b, input pix_t c,
		input pix_t mask);
		pix_t am;
		pix_t bm;
		pix_t cm;
		am = a & mask;
		bm = b & mask;
		cm = c & mask;
		return am + {bm[PIX_W-2:0], 1'b0} + cm;
	endfunction

endpackage

// ----- sv/packed_rgb_3x3_blur.sv -----
// Packed RGB 3x3 binomial blur: line stores, window, two-step kernel sum, output register.
// An item that yields a pixel passes stage 1, stage 2 and the output register in turn.
// Throughput: one beat per cycle while not stalled; one-port line store reads set this.
// Output lags input by frame_width+1 beats; the host flushes each frame with that many.
// Reset clears control and config; a clearing pass then zeroes both line stores,
// with in_stall high while it runs (config writes still accepted).
`timescale 1ns / 1ps

module packed_rgb_3x3_blur import prgbblur_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	// input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              kind,
	input  logic [PIX_W-1:0]  pixel,
	// output channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PIX_W-1:0]  pixel_out,
	output logic              last_of_frame
);

	// config registers
	logic                blur_en_q;
	logic [WIDTH_W-1:0]  frame_width_q;
	logic [HEIGHT_W-1:0] frame_height_q;
	pix_t                rb_mask_q;
	pix_t                g_mask_q;
	logic                cfg_wr;
	reg_idx_t            cfg_idx;

	// line stores
	pix_t upper_mem [MAX_WIDTH];
	pix_t middle_mem [MAX_WIDTH];
	logic             mem_we;
	logic [COL_W-1:0] mem_waddr;
	pix_t             mem_wtop;
	pix_t             mem_wmid;
	logic [CLR_W-1:0] clr_cnt_q;
	logic             clearing;

	// position counters
	logic [COL_W-1:0]    in_col_q;
	logic [ROW_W-1:0]    in_row_q;
	logic [COL_W-1:0]    out_col_q;
	logic [HEIGHT_W-1:0] out_row_q;

	// accept-side decode
	logic [WIDTH_W-1:0]  w_eff;
	logic [HEIGHT_W-1:0] h_eff;
	logic [WIDTH_W-1:0]  in_col_inc;
	logic                in_col_end;
	logic                emit;
	logic                row_end;
	logic                col_end;
	logic                last;
	logic                accept;

	// stage 1
	logic             s1_v;
	logic [COL_W-1:0] col_s1;
	pix_t             pix_s1;
	pix_t             top_s1;
	pix_t             mid_s1;
	logic             emit_s1;
	logic             last_s1;
	edge_sel_t        sel_s1;
	logic             s1_move;
	pix_t             top_eff;
	pix_t             mid_eff;

	// write-through bypass for a same-column read on the commit edge
	logic             fwd_v_q;
	logic [COL_W-1:0] fwd_col_q;
	pix_t             fwd_top_q;
	pix_t             fwd_mid_q;

	// window, row-major, column 2 newest
	pix_t win_q [9];
	pix_t win_nx [9];
	pix_t rs_rb [3];
	pix_t rs_g [3];
	pix_t sel_row [3][3];

	// stage 2
	logic s2_v;
	pix_t rb_s2 [3];
	pix_t g_s2 [3];
	pix_t center_s2;
	logic last_s2;
	logic s2_move;
	pix_t rb_sum;
	pix_t g_sum;
	pix_t blur_px;

	// output register
	logic out_v_q;
	pix_t pix_out_q;
	logic last_out_q;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blur_en_q      <= 1'b0;
			frame_width_q  <= WIDTH_RST;
			frame_height_q <= HEIGHT_RST;
			rb_mask_q      <= RB_MASK_RST;
			g_mask_q       <= G_MASK_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_BLUR_ENABLE:   blur_en_q      <= pwdata[0];
				REG_FRAME_WIDTH:   frame_width_q  <= pwdata[WIDTH_W-1:0];
				REG_FRAME_HEIGHT:  frame_height_q <= pwdata[HEIGHT_W-1:0];
				REG_RED_BLUE_MASK: rb_mask_q      <= pwdata;
				REG_GREEN_MASK:    g_mask_q       <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_BLUR_ENABLE:   prdata = {{(DATA_W-1){1'b0}}, blur_en_q};
			REG_FRAME_WIDTH:   prdata = {{(DATA_W-WIDTH_W){1'b0}}, frame_width_q};
			REG_FRAME_HEIGHT:  prdata = {{(DATA_W-HEIGHT_W){1'b0}}, frame_height_q};
			REG_RED_BLUE_MASK: prdata = rb_mask_q;
			REG_GREEN_MASK:    prdata = g_mask_q;
			default:           prdata = '0;
		endcase
	end

	// ---------------- handshake ----------------
	assign clearing = !clr_cnt_q[CLR_W-1];
	assign s2_move  = s2_v && (!out_v_q || !out_stall);
	assign s1_move  = s1_v && (!emit_s1 || !s2_v || s2_move);
	assign in_stall = clearing || (s1_v && !s1_move);
	assign accept   = in_valid && !in_stall;

	// ---------------- position tracking at the input beat ----------------
	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = WIDTH_W'(1);
		end else if (frame_width_q > WIDTH_MAX) begin
			w_eff = WIDTH_MAX;
		end else begin
			w_eff = frame_width_q;
		end
		h_eff      = (frame_height_q == '0) ? HEIGHT_W'(1) : frame_height_q;
		in_col_inc = WIDTH_W'(in_col_q) + WIDTH_W'(1);
		in_col_end = in_col_inc >= w_eff;
		emit       = (in_row_q >= ROW_W'(2)) || (in_row_q == ROW_W'(1) && in_col_q != '0);
		row_end    = (ROW_W'(out_row_q) + ROW_W'(1)) >= ROW_W'(h_eff);
		col_end    = (WIDTH_W'(out_col_q) + WIDTH_W'(1)) >= w_eff;
		last       = emit && row_end && col_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (accept) begin
			if (last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_col_end) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + ROW_W'(1);
				end else begin
					in_col_q <= in_col_inc[COL_W-1:0];
				end
				if (emit) begin
					if (col_end) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + HEIGHT_W'(1);
					end else begin
						out_col_q <= out_col_q + COL_W'(1);
					end
				end
			end
		end
	end

	// ---------------- line stores ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (clearing) begin
			clr_cnt_q <= clr_cnt_q + CLR_W'(1);
		end
	end

	assign mem_we    = clearing || s1_move;
	assign mem_waddr = clearing ? clr_cnt_q[COL_W-1:0] : col_s1;
	assign mem_wtop  = clearing ? '0 : mid_eff;
	assign mem_wmid  = clearing ? '0 : pix_s1;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			upper_mem[mem_waddr]  <= mem_wtop;
			middle_mem[mem_waddr] <= mem_wmid;
		end
		if (accept) begin
			top_s1 <= upper_mem[in_col_q];
			mid_s1 <= middle_mem[in_col_q];
		end
	end

	// ---------------- stage 1 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v    <= 1'b0;
			fwd_v_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_v    <= 1'b1;
				fwd_v_q <= s1_move;
			end else if (s1_move) begin
				s1_v <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1         <= in_col_q;
			pix_s1         <= kind ? '0 : pixel;
			emit_s1        <= emit;
			last_s1        <= last;
			sel_s1.top     <= (out_row_q == '0);
			sel_s1.bottom  <= row_end;
			sel_s1.left    <= (out_col_q == '0);
			sel_s1.right   <= col_end;
			fwd_col_q      <= col_s1;
			fwd_top_q      <= mid_eff;
			fwd_mid_q      <= pix_s1;
		end
	end

	always_comb begin
		if (fwd_v_q && fwd_col_q == col_s1) begin
			top_eff = fwd_top_q;
			mid_eff = fwd_mid_q;
		end else begin
			top_eff = top_s1;
			mid_eff = mid_s1;
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_nx[r*3]     = win_q[r*3+1];
			win_nx[r*3 + 1] = win_q[r*3+2];
		end
		win_nx[2] = top_eff;
		win_nx[5] = mid_eff;
		win_nx[8] = pix_s1;
		// replicate rows and columns at the frame border
		for (int c = 0; c < 3; c++) begin
			sel_row[0][c] = sel_s1.top ? win_nx[3+c] : win_nx[c];
			sel_row[1][c] = win_nx[3+c];
			sel_row[2][c] = sel_s1.bottom ? win_nx[3+c] : win_nx[6+c];
		end
		for (int v = 0; v < 3; v++) begin
			rs_rb[v] = row_sum(sel_s1.left ? sel_row[v][1] : sel_row[v][0], sel_row[v][1],
				sel_s1.right ? sel_row[v][1] : sel_row[v][2], rb_mask_q);
			rs_g[v]  = row_sum(sel_s1.left ? sel_row[v][1] : sel_row[v][0], sel_row[v][1],
				sel_s1.right ? sel_row[v][1] : sel_row[v][2], g_mask_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_move) begin
			win_q <= win_nx;
		end
	end

	// ---------------- stage 2 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v <= 1'b0;
		end else if (s1_move && emit_s1) begin
			s2_v <= 1'b1;
		end else if (s2_move) begin
			s2_v <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && emit_s1) begin
			rb_s2     <= rs_rb;
			g_s2      <= rs_g;
			center_s2 <= win_nx[4];
			last_s2   <= last_s1;
		end
	end

	always_comb begin
		rb_sum  = rb_s2[0] + {rb_s2[1][PIX_W-2:0], 1'b0} + rb_s2[2];
		g_sum   = g_s2[0] + {g_s2[1][PIX_W-2:0], 1'b0} + g_s2[2];
		blur_px = ((rb_sum >> 4) & rb_mask_q) | ((g_sum >> 4) & g_mask_q);
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s2_move) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			pix_out_q  <= blur_en_q ? blur_px : center_s2;
			last_out_q <= last_s2;
		end
	end

	assign out_valid     = out_v_q;
	assign pixel_out     = pix_out_q;
	assign last_of_frame = last_out_q;

endmodule
